// ===== rtl/kcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// kcfc_pkg
// Shared constants, codes, reply record and CRC-8 step for the keyed command
// frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package kcfc_pkg;

  localparam logic [7:0] HDR0          = 8'hA3;
  localparam logic [7:0] HDR1          = 8'hA4;
  localparam logic [7:0] SCR_OFS       = 8'h32;
  localparam logic [7:0] KEY_OFS       = 8'h28;
  localparam logic [7:0] ERR_CMD       = 8'h10;
  localparam logic [7:0] CMD_GETKEY    = 8'h01;
  localparam logic [7:0] CMD_FIRST     = 8'h20;
  localparam logic [7:0] CMD_UNLOCK    = 8'h21;
  localparam logic [7:0] CMD_LOCK      = 8'h22;
  localparam logic [7:0] CMD_LAMP      = 8'h23;
  localparam logic [7:0] CMD_LAST      = 8'h24;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [7:0] PW_MIN_LEN    = 8'd8;

  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] COUNT_MAX      = '1;
  localparam logic [CNT_W-1:0] FRAME_OVERHEAD = 9'd6;

  // Reply body holds all plaintext bytes ahead of the CRC
  localparam int unsigned BODY_BYTES = 8;
  localparam int unsigned IDX_W      = 4;
  localparam logic [IDX_W-1:0] SCR_FIRST   = 4'd4;
  localparam logic [IDX_W-1:0] CRC_IDX_STD = 4'd7;
  localparam logic [IDX_W-1:0] CRC_IDX_KEY = 4'd8;

  localparam int unsigned PW_W   = 63;

  typedef enum logic [7:0] {
    ERR_CRC         = 8'd1,
    ERR_NO_KEY      = 8'd2,
    ERR_KEY_WRONG   = 8'd3,
    ERR_HEADER      = 8'd4,
    ERR_LENGTH      = 8'd5,
    ERR_CMD_UNKNOWN = 8'd6
  } err_code_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_UNLOCK     = 3'd1,
    ACT_LOCK       = 3'd2,
    ACT_LAMP       = 3'd3,
    ACT_REBOOT     = 3'd4,
    ACT_SET_SERVER = 3'd5,
    ACT_DISCONNECT = 3'd6
  } action_e;

  typedef enum logic [0:0] {
    CFG_RAND     = 1'b0,
    CFG_PASSWORD = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [BODY_BYTES-1:0][7:0] body;     // body[0] goes out first
    logic                       nine;     // 9-byte reply (get-key)
    action_e                    action;
    logic [7:0]                 scramble;
  } reply_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kcfc_reply_tx.sv =====
// ----------------------------------------------------------------------------
// kcfc_reply_tx
// Serializes one reply: sends the body bytes, scrambling from byte 4 on, and
// appends the CRC-8 taken over the plaintext.
// ----------------------------------------------------------------------------
`default_nettype none

module kcfc_reply_tx
  import kcfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire reply_t      reply_i,
  output logic             busy_o,
  output logic             tx_valid_o,
  input  wire logic        tx_ready_i,
  output logic [7:0]       tx_byte_o,
  output logic             tx_last_o,
  output logic [2:0]       tx_action_o
);

  logic                       busy_q;
  logic [BODY_BYTES-1:0][7:0] body_q;
  logic [IDX_W-1:0]           idx_q;
  logic [7:0]                 crc_q;
  logic                       nine_q;
  action_e                    action_q;
  logic [7:0]                 scr_q;

  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic [2:0] out_act_q;

  logic             step;
  logic             at_crc;
  logic [IDX_W-1:0] crc_idx;
  logic [7:0]       body_tx;

  assign crc_idx = nine_q ? CRC_IDX_KEY : CRC_IDX_STD;
  assign at_crc  = (idx_q == crc_idx);
  assign step    = busy_q && (!out_vld_q || tx_ready_i);
  assign body_tx = body_q[0] ^ ((idx_q >= SCR_FIRST) ? scr_q : 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      idx_q      <= '0;
      crc_q      <= '0;
      nine_q     <= 1'b0;
      action_q   <= ACT_NONE;
      scr_q      <= '0;
      body_q     <= '0;
      out_byte_q <= '0;
      out_last_q <= 1'b0;
      out_act_q  <= '0;
    end else begin
      if (load_i) begin
        busy_q   <= 1'b1;
        body_q   <= reply_i.body;
        idx_q    <= '0;
        crc_q    <= '0;
        nine_q   <= reply_i.nine;
        action_q <= reply_i.action;
        scr_q    <= reply_i.scramble;
      end else if (step) begin
        if (at_crc) begin
          out_byte_q <= crc_q;
          out_last_q <= 1'b1;
          out_act_q  <= action_q;
          busy_q     <= 1'b0;
        end else begin
          out_byte_q <= body_tx;
          out_last_q <= 1'b0;
          out_act_q  <= ACT_NONE;
          crc_q      <= crc_byte(crc_q, body_q[0]);
          body_q     <= {8'h00, body_q[BODY_BYTES-1:1]};
          idx_q      <= idx_q + 1'b1;
        end
      end

      if (step) begin
        out_vld_q <= 1'b1;
      end else if (tx_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign busy_o      = busy_q;
  assign tx_valid_o  = out_vld_q;
  assign tx_byte_o   = out_byte_q;
  assign tx_last_o   = out_last_q;
  assign tx_action_o = out_act_q;

endmodule

`default_nettype wire

// ===== rtl/keyed_command_frame_checker.sv =====
// ----------------------------------------------------------------------------
// keyed_command_frame_checker
// Checks received command frames byte by byte (header, length, CRC-8, session
// key) and answers each frame with a scrambled reply frame.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata = rx_byte, tlast = frame_end
// m_axis    out  m_axis_tvalid/tready    tdata = tx_byte, tlast = reply_last,
//                                        tuser = action
// cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// One input byte is taken per cycle; a non-final byte never waits in the input register.
// A final byte waits there while the previous reply is still being sent and holds
// off the input; each reply goes out at one byte per cycle while m_axis_tready is high
// (8 or 9 transfers), and the serializer goes idle before the next reply is loaded.
// A final byte in the input register loads the reply; the serializer registers each byte out.
// Reset clears the frame state and the session key and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_command_frame_checker
  import kcfc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  input  wire logic              s_axis_tlast,
  // output stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] tx_byte
  output logic                   m_axis_tlast,
  output logic [2:0]             m_axis_tuser,   // [2:0] action
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [PW_W-1:0]   cfg_data_i
);

  // configuration registers
  logic [7:0]      rand_value_q;
  logic [PW_W-1:0] password_q;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // frame state
  logic [CNT_W-1:0] cnt_q;
  logic [7:0]       run_crc_q;
  logic             hdr_good_q;
  logic [7:0]       len_q;
  logic [7:0]       frame_rand_q;
  logic [7:0]       key_q;
  logic [7:0]       cmd_q;
  logic             pw_match_q;
  logic [7:0]       session_key_q;

  logic   acc;
  logic   adv;
  logic   reply_busy;
  logic   reply_load;
  reply_t reply;

  logic [7:0]       plain;
  logic             hdr_ok;
  logic [CNT_W-1:0] len_total;
  logic [2:0]       pw_sel;
  logic [63:0]      pw_full;
  logic [7:0]       pw_byte;
  logic             in_pw_range;
  logic [7:0]       sess_d;
  logic [7:0]       new_key;
  logic             pw_ok;
  err_code_e        err_code;
  logic             err;

  assign adv           = in_vld_q && (!in_last_q || !reply_busy);
  assign s_axis_tready = !in_vld_q || adv;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign reply_load    = adv && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rand_value_q <= 8'h55;
      password_q   <= 63'h4D6F_6269_7443_6172;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RAND:     rand_value_q <= cfg_data_i[7:0];
        CFG_PASSWORD: password_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      in_byte_q <= '0;
      in_last_q <= 1'b0;
    end else if (acc) begin
      in_vld_q  <= 1'b1;
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end else if (adv) begin
      in_vld_q  <= 1'b0;
    end
  end

  // Per-byte decode
  assign plain       = in_byte_q ^ (frame_rand_q - SCR_OFS);
  assign hdr_ok      = hdr_good_q
                       && !(cnt_q == CNT_W'(0) && in_byte_q != HDR0)
                       && !(cnt_q == CNT_W'(1) && in_byte_q != HDR1);
  assign len_total   = {1'b0, len_q} + FRAME_OVERHEAD;
  assign in_pw_range = (cnt_q >= CNT_W'(6)) && (cnt_q <= CNT_W'(13));
  assign pw_sel      = 3'(cnt_q - CNT_W'(6));
  assign pw_full     = {1'b0, password_q};
  assign pw_byte     = pw_full[{~pw_sel, 3'b000} +: 8];
  assign new_key     = rand_value_q + KEY_OFS;
  assign pw_ok       = pw_match_q && (len_q >= PW_MIN_LEN);

  // Reply decision for a final byte
  always_comb begin
    err      = 1'b0;
    err_code = ERR_HEADER;
    sess_d   = session_key_q;
    reply.body     = '0;
    reply.nine     = 1'b0;
    reply.action   = ACT_NONE;
    reply.scramble = rand_value_q;
    reply.body[0]  = HDR0;
    reply.body[1]  = HDR1;
    reply.body[3]  = rand_value_q + SCR_OFS;

    if (!hdr_ok || cnt_q < CNT_W'(2)) begin
      err = 1'b1; err_code = ERR_HEADER;
    end else if (cnt_q < FRAME_OVERHEAD || cnt_q != len_total) begin
      err = 1'b1; err_code = ERR_LENGTH;
    end else if (in_byte_q != run_crc_q) begin
      err = 1'b1; err_code = ERR_CRC;
    end else if (cmd_q != CMD_GETKEY && session_key_q == 8'h00) begin
      err = 1'b1; err_code = ERR_NO_KEY;
    end else if (cmd_q != CMD_GETKEY && key_q != session_key_q) begin
      err = 1'b1; err_code = ERR_KEY_WRONG;
    end else if (cmd_q == CMD_GETKEY) begin
      sess_d        = new_key;
      reply.nine    = 1'b1;
      reply.body[2] = 8'h02;
      reply.body[4] = pw_ok ? new_key : 8'h00;
      reply.body[5] = CMD_GETKEY;
      reply.body[6] = pw_ok ? 8'h01 : 8'h00;
      reply.body[7] = pw_ok ? new_key : 8'h00;
    end else begin
      reply.body[2] = 8'h01;
      reply.body[4] = session_key_q;
      reply.body[5] = cmd_q;
      reply.body[6] = 8'h01;
      case (cmd_q)
        CMD_FIRST:  reply.action = ACT_SET_SERVER;
        CMD_UNLOCK: reply.action = ACT_UNLOCK;
        CMD_LOCK:   reply.action = ACT_LOCK;
        CMD_LAMP:   reply.action = ACT_LAMP;
        CMD_LAST:   reply.action = ACT_REBOOT;
        default: begin
          err = 1'b1; err_code = ERR_CMD_UNKNOWN;
        end
      endcase
    end

    if (err) begin
      sess_d        = 8'h00;
      reply.nine    = 1'b0;
      reply.action  = ACT_DISCONNECT;
      reply.body[2] = 8'h01;
      reply.body[4] = 8'h00;
      reply.body[5] = ERR_CMD;
      reply.body[6] = err_code;
      reply.body[7] = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      run_crc_q     <= '0;
      hdr_good_q    <= 1'b1;
      len_q         <= '0;
      frame_rand_q  <= '0;
      key_q         <= '0;
      cmd_q         <= '0;
      pw_match_q    <= 1'b1;
      session_key_q <= '0;
    end else if (adv) begin
      if (in_last_q) begin
        // close the frame and start over
        cnt_q         <= '0;
        run_crc_q     <= '0;
        hdr_good_q    <= 1'b1;
        len_q         <= '0;
        frame_rand_q  <= '0;
        key_q         <= '0;
        cmd_q         <= '0;
        pw_match_q    <= 1'b1;
        session_key_q <= sess_d;
      end else begin
        hdr_good_q <= hdr_ok;
        run_crc_q  <= crc_byte(run_crc_q, in_byte_q);
        if (cnt_q != COUNT_MAX) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cnt_q == CNT_W'(2)) begin
          len_q <= in_byte_q;
        end
        if (cnt_q == CNT_W'(3)) begin
          frame_rand_q <= in_byte_q;
        end
        if (cnt_q == CNT_W'(4)) begin
          key_q <= plain;
        end
        if (cnt_q == CNT_W'(5)) begin
          cmd_q <= plain;
        end
        if (in_pw_range && plain != pw_byte) begin
          pw_match_q <= 1'b0;
        end
      end
    end
  end

  kcfc_reply_tx u_reply_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (reply_load),
    .reply_i     (reply),
    .busy_o      (reply_busy),
    .tx_valid_o  (m_axis_tvalid),
    .tx_ready_i  (m_axis_tready),
    .tx_byte_o   (m_axis_tdata),
    .tx_last_o   (m_axis_tlast),
    .tx_action_o (m_axis_tuser)
  );

  // A new reply never lands on one still being sent
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_load |-> !reply_busy)
    else $error("reply loaded while serializer busy");

  // Only the closing byte of a reply carries an action
  a_action_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == ACT_NONE))
    else $error("action on a non-final reply byte");

  // An error reply always drops the session key
  a_err_clears_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reply_load && err) |=> (session_key_q == 8'h00))
    else $error("session key kept after error reply");

endmodule

`default_nettype wire
